@@ rtl/crs_pkg.sv @@
// shared types and constants for the clip rectangle stack
package crs_pkg;

   localparam int STACK_DEPTH_DEF = 16;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_POP_EMPTY = 2'd1,
      ST_PUSH_FULL = 2'd2,
      ST_RSVD      = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] bottom;
      logic [14:0]        span_x;
      logic [14:0]        span_y;
   } rect_type;

   localparam int RECT_W = $bits(rect_type);

   typedef struct packed {
      opcode_type         opcode;
      logic signed [15:0] left;
      logic signed [15:0] bottom;
      logic [14:0]        span_x;
      logic [14:0]        span_y;
   } req_type;

   typedef struct packed {
      logic               clip_enable;
      logic signed [15:0] clip_left;
      logic signed [15:0] clip_bottom;
      logic [14:0]        clip_span_x;
      logic [14:0]        clip_span_y;
      status_type         status;
   } rsp_type;

endpackage

@@ rtl/crs_ram.sv @@
// generic single write port ram with registered read
module crs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/clip_rect_stack.sv @@
// clip rectangle stack top level: push intersects with the top, pop restores the one below
//
// usage
//  - request channel: a transaction is taken at a rising edge with start high and busy low;
//    req_data carries opcode, left, bottom, span_x and span_y (geometry ignored on a pop)
//  - response channel: rsp_strobe is high for exactly one cycle per transaction, with
//    rsp_data holding the rectangle now on top, clip_enable and a status code
//  - the receiver cannot stall; every response must be taken in its strobe cycle
//  - push: result in the cycle after acceptance, a new push may follow in the next cycle
//  - pop exposing a lower entry: the entry is fetched from the stack ram (registered read),
//    busy is high while S_POP_RD waits for the read, then the result is registered from it
//  - pop down to empty, pop on empty and push on full: result in the cycle after acceptance
//  - sustained rate: one push per cycle; a pop that uncovers an entry holds off the next
//    request while busy is high for the ram read
//  - the current top rectangle is kept in a register so a push needs no ram read
//  - reset empties the stack and clears busy; ram contents are left as they are
//  - status: done, pop on empty ignored, push on full ignored
module clip_rect_stack #(
   parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  crs_pkg::req_type req_data,
   output logic             rsp_strobe,
   output crs_pkg::rsp_type rsp_data
);

   localparam int ADDR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LVL_W    = $clog2(STACK_DEPTH + 1);
   localparam int RECT_W_L = crs_pkg::RECT_W;

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_POP_RD = 2'b10
   } state_type;

   // one axis of the intersection: larger low edge, smaller high edge, span clamped at zero
   function automatic logic [30:0] axis_clip(
      input logic [15:0] lo_a,
      input logic [14:0] span_a,
      input logic [15:0] lo_b,
      input logic [14:0] span_b
   );
      logic signed [16:0] a_lo;
      logic signed [16:0] b_lo;
      logic signed [16:0] a_hi;
      logic signed [16:0] b_hi;
      logic signed [16:0] n_lo;
      logic signed [16:0] n_hi;
      logic [17:0]        diff;
      logic [14:0]        span;
      a_lo = {lo_a[15], lo_a};
      b_lo = {lo_b[15], lo_b};
      a_hi = a_lo + $signed({2'b00, span_a});
      b_hi = b_lo + $signed({2'b00, span_b});
      n_lo = (a_lo > b_lo) ? a_lo : b_lo;
      n_hi = (a_hi < b_hi) ? a_hi : b_hi;
      diff = {n_hi[16], n_hi} - {n_lo[16], n_lo};
      span = diff[17] ? 15'd0 : diff[14:0];
      return {n_lo[15:0], span};
   endfunction

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] level_ff, level_in;
   crs_pkg::rect_type top_ff, top_in;
   crs_pkg::rsp_type  rsp_ff, rsp_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   logic              accept;
   logic              is_push;
   logic              stack_full;
   logic              stack_empty;
   crs_pkg::rect_type push_rect;
   logic [30:0]       clip_x;
   logic [30:0]       clip_y;
   logic              ram_we;
   logic              ram_re;
   logic [LVL_W-1:0]  below_level;
   logic [RECT_W_L-1:0] ram_rd_data;
   crs_pkg::rect_type ram_rect;

   assign busy        = (state_ff == S_POP_RD);
   assign accept      = start && !busy;
   assign is_push     = (req_data.opcode == crs_pkg::OP_PUSH);
   assign stack_full  = (level_ff == LVL_W'(STACK_DEPTH));
   assign stack_empty = (level_ff == '0);
   assign below_level = level_ff - LVL_W'(2);

   // intersection of the incoming rectangle with the registered top
   assign clip_x = axis_clip(req_data.left, req_data.span_x, top_ff.left, top_ff.span_x);
   assign clip_y = axis_clip(req_data.bottom, req_data.span_y, top_ff.bottom, top_ff.span_y);

   always_comb begin
      if (stack_empty) begin
         push_rect.left   = req_data.left;
         push_rect.bottom = req_data.bottom;
         push_rect.span_x = req_data.span_x;
         push_rect.span_y = req_data.span_y;
      end else begin
         push_rect.left   = clip_x[30:15];
         push_rect.bottom = clip_y[30:15];
         push_rect.span_x = clip_x[14:0];
         push_rect.span_y = clip_y[14:0];
      end
   end

   assign ram_we   = accept && is_push && !stack_full;
   assign ram_re   = accept && !is_push && (level_ff > LVL_W'(1));
   assign ram_rect = crs_pkg::rect_type'(ram_rd_data);

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      top_in        = top_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               rsp_in.status = crs_pkg::ST_DONE;
               if (is_push) begin
                  if (stack_full) begin
                     // ignored: report the unchanged top
                     rsp_in.status      = crs_pkg::ST_PUSH_FULL;
                     rsp_in.clip_enable = 1'b1;
                     rsp_in.clip_left   = top_ff.left;
                     rsp_in.clip_bottom = top_ff.bottom;
                     rsp_in.clip_span_x = top_ff.span_x;
                     rsp_in.clip_span_y = top_ff.span_y;
                  end else begin
                     level_in           = level_ff + LVL_W'(1);
                     top_in             = push_rect;
                     rsp_in.clip_enable = 1'b1;
                     rsp_in.clip_left   = push_rect.left;
                     rsp_in.clip_bottom = push_rect.bottom;
                     rsp_in.clip_span_x = push_rect.span_x;
                     rsp_in.clip_span_y = push_rect.span_y;
                  end
               end else if (stack_empty) begin
                  rsp_in.status = crs_pkg::ST_POP_EMPTY;
               end else begin
                  level_in = level_ff - LVL_W'(1);
                  if (level_ff > LVL_W'(1)) begin
                     // entry below is on its way from the ram
                     rsp_strobe_in = 1'b0;
                     state_in      = S_POP_RD;
                  end
               end
            end
         end
         S_POP_RD: begin
            top_in             = ram_rect;
            rsp_strobe_in      = 1'b1;
            rsp_in             = '0;
            rsp_in.status      = crs_pkg::ST_DONE;
            rsp_in.clip_enable = 1'b1;
            rsp_in.clip_left   = ram_rect.left;
            rsp_in.clip_bottom = ram_rect.bottom;
            rsp_in.clip_span_x = ram_rect.span_x;
            rsp_in.clip_span_y = ram_rect.span_y;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         level_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         level_ff      <= level_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   crs_ram #(
      .WIDTH (RECT_W_L),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (level_ff[ADDR_W-1:0]),
      .wr_data (push_rect),
      .rd_en   (ram_re),
      .rd_addr (below_level[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // stack level stays within the ram
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(STACK_DEPTH))
      else $error("stack level beyond depth");

   // the ram read wait state returns to idle in the next cycle
   a_pop_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP_RD |=> state_ff == S_IDLE)
      else $error("pop read wait not one cycle");

   // every pop that uncovers an entry answers after the read
   a_pop_answers: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP_RD |=> rsp_strobe_ff)
      else $error("pop read without response");

   // a push transaction answers on the next cycle
   a_push_answers: assert property (@(posedge clock) disable iff (reset)
      accept && is_push |=> rsp_strobe_ff)
      else $error("push without response");

   // reported enable matches stack occupancy
   a_enable_level: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> rsp_ff.clip_enable == (level_ff != '0))
      else $error("clip enable disagrees with stack level");

endmodule

@@ verif/tb_clip_rect_stack.sv @@
// self-checking testbench for the clip rectangle stack: directed table, then random push/pop traffic
`timescale 1ns / 1ps

module tb_clip_rect_stack;

   localparam int DEPTH          = crs_pkg::STACK_DEPTH_DEF;
   localparam int RANDOM_ITEMS   = 400;
   localparam int QUIET_LIMIT    = 200;   // cycles with no transaction either way
   localparam int REPORT_LIMIT   = 10;

   // one row of the directed stimulus; typed rows carry the expected response
   typedef struct {
      crs_pkg::opcode_type op;
      int                  left;
      int                  bottom;
      int                  span_x;
      int                  span_y;
      bit                  typed;
      bit                  w_en;
      int                  w_left;
      int                  w_bottom;
      int                  w_span_x;
      int                  w_span_y;
      crs_pkg::status_type w_status;
   } dir_row_type;

   localparam int DIR_ROWS = 25;

   // walks through empty, extremes, full and back; untyped rows go to the predictor
   // each row: opcode, left, bottom, span_x, span_y, typed, then the expected response
   dir_row_type dir_table [DIR_ROWS] = '{
      // pop on an empty stack straight after reset, geometry must be ignored
      '{crs_pkg::OP_POP,    1234,  -4321,    77,    88, 1,
        0,      0,      0,     0,     0, crs_pkg::ST_POP_EMPTY},
      // most negative corner with the widest spans
      '{crs_pkg::OP_PUSH, -32768, -32768, 32767, 32767, 1,
        1, -32768, -32768, 32767, 32767, crs_pkg::ST_DONE},
      // most positive corner, intersection collapses to zero spans
      '{crs_pkg::OP_PUSH,  32767,  32767, 32767, 32767, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_POP,      -1,     -1, 32767, 32767, 1,
        1, -32768, -32768, 32767, 32767, crs_pkg::ST_DONE},
      // pop down to empty clears the rectangle
      '{crs_pkg::OP_POP,   32767,  32767,     0,     0, 1,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,  32767,  32767,     0,     0, 1,
        1,  32767,  32767,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_POP,       0,      0,     0,     0, 1,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      // fill the stack to the brim with a mix of overlaps
      '{crs_pkg::OP_PUSH,   -100,   -200,  1000,  2000, 1,
        1,   -100,   -200,  1000,  2000, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,   -150,   -150,   100,   100, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,   -120,   -120,    10,   500, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH, -32768, -32768, 32767, 32767, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,   -115,   -100,     3,     3, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,   -112,    -97,     5,     5, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,   -200,   -200,    88,   103, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,      0,      0,     0,     0, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,   1000,  -1000,     5,     5, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,  32767,  32767, 32767, 32767, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH, -32768,  32767,     0, 32767, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,  12345, -12345,     7,     7, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,     -1,     -1,     1,     1, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,      0,     -1, 32767,     0, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH, -32768, -32768,     0,     0, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      '{crs_pkg::OP_PUSH,  21845, -21846, 10922, 21845, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE},
      // push on a full stack is refused
      '{crs_pkg::OP_PUSH,      5,      5,     5,     5, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_PUSH_FULL},
      '{crs_pkg::OP_POP,   32767, -32768, 32767, 32767, 0,
        0,      0,      0,     0,     0, crs_pkg::ST_DONE}
   };

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             start      = 1'b0;
   logic             busy;
   crs_pkg::req_type req_data   = '0;
   logic             rsp_strobe;
   crs_pkg::rsp_type rsp_data;

   // shadow copy of the stack, updated as each transaction is taken
   crs_pkg::rect_type shadow_rects [DEPTH];
   int                shadow_level = 0;

   crs_pkg::rsp_type  pending_clips [$];   // expected responses, oldest first
   bit                item_typed = 1'b0;   // current directed row has a typed expectation
   crs_pkg::rsp_type  item_want  = '0;
   int                send_idle_pct = 35;

   int errors       = 0;
   int quiet_cycles = 0;
   int n_push       = 0;
   int n_pop        = 0;
   int n_push_full  = 0;
   int n_pop_empty  = 0;
   int n_rsp        = 0;
   int deepest      = 0;

   clip_rect_stack #(
      .STACK_DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // top rectangle after one transaction; updates the shadow stack as a side effect
   function automatic crs_pkg::rsp_type clip_after(crs_pkg::req_type rq);
      crs_pkg::rsp_type  res;
      crs_pkg::rect_type top;
      crs_pkg::rect_type nr;
      int                nl;
      int                nb;
      int                rr;
      int                rt;
      res        = '0;
      res.status = crs_pkg::ST_DONE;
      if (rq.opcode == crs_pkg::OP_PUSH) begin
         if (shadow_level >= DEPTH) begin
            res.status = crs_pkg::ST_PUSH_FULL;
         end else begin
            nr.left   = rq.left;
            nr.bottom = rq.bottom;
            nr.span_x = rq.span_x;
            nr.span_y = rq.span_y;
            if (shadow_level > 0) begin
               top = shadow_rects[shadow_level - 1];
               // larger lower edges, smaller upper edges, spans clamped at zero
               nl = (int'($signed(rq.left)) > int'($signed(top.left))) ?
                    int'($signed(rq.left)) : int'($signed(top.left));
               nb = (int'($signed(rq.bottom)) > int'($signed(top.bottom))) ?
                    int'($signed(rq.bottom)) : int'($signed(top.bottom));
               rr = int'($signed(rq.left)) + int'(rq.span_x);
               if (int'($signed(top.left)) + int'(top.span_x) < rr)
                  rr = int'($signed(top.left)) + int'(top.span_x);
               rt = int'($signed(rq.bottom)) + int'(rq.span_y);
               if (int'($signed(top.bottom)) + int'(top.span_y) < rt)
                  rt = int'($signed(top.bottom)) + int'(top.span_y);
               nr.left   = 16'(nl);
               nr.bottom = 16'(nb);
               nr.span_x = (rr > nl) ? 15'(rr - nl) : 15'd0;
               nr.span_y = (rt > nb) ? 15'(rt - nb) : 15'd0;
            end
            shadow_rects[shadow_level] = nr;
            shadow_level++;
         end
      end else if (shadow_level == 0) begin
         res.status = crs_pkg::ST_POP_EMPTY;
      end else begin
         shadow_level--;
      end
      if (shadow_level > 0) begin
         top             = shadow_rects[shadow_level - 1];
         res.clip_enable = 1'b1;
         res.clip_left   = top.left;
         res.clip_bottom = top.bottom;
         res.clip_span_x = top.span_x;
         res.clip_span_y = top.span_y;
      end
      return res;
   endfunction

   // coordinate with a strong pull towards the extremes and zero
   function automatic int pick_coord();
      logic signed [15:0] v;
      v = 16'($urandom);
      case ($urandom_range(0, 7))
         0: v = -16'sd32768;
         1: v = 16'sd32767;
         2: v = '0;
         default: ;
      endcase
      return int'(v);
   endfunction

   function automatic int pick_span();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 32767;
         default: return $urandom_range(0, 32767);
      endcase
   endfunction

   // nudge a coordinate of the top rectangle so that pushes mostly overlap it
   function automatic int jitter_coord(int base);
      int v;
      v = base + $urandom_range(0, 80) - 40;
      return (v < -32768) ? -32768 : (v > 32767) ? 32767 : v;
   endfunction

   function automatic int jitter_span(int base);
      int v;
      v = base + $urandom_range(0, 60) - 20;
      return (v < 0) ? 0 : (v > 32767) ? 32767 : v;
   endfunction

   // present one transaction at the falling edge and hold it until busy is low at a rising edge
   task automatic send_item(crs_pkg::req_type rq, bit typed, crs_pkg::rsp_type want);
      // each cycle the sender idles with the given percentage
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start      <= 1'b1;
      req_data   <= rq;
      item_typed  = typed;
      item_want   = want;
      do
         @(posedge clock);
      while (busy !== 1'b0);
   endtask

   // response check first, then take the new transaction, all on the rising edge
   always @(posedge clock) begin : monitor
      crs_pkg::rsp_type want;
      bit               moved;
      bit               bad;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (rsp_strobe === 1'b1) begin
            moved = 1'b1;
            n_rsp++;
            if (pending_clips.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: response with nothing pending: %p", $realtime, rsp_data);
            end else begin
               want = pending_clips.pop_front();
               bad  = (rsp_data.clip_enable !== want.clip_enable) ||
                      (rsp_data.clip_left   !== want.clip_left)   ||
                      (rsp_data.clip_bottom !== want.clip_bottom) ||
                      (rsp_data.clip_span_x !== want.clip_span_x) ||
                      (rsp_data.clip_span_y !== want.clip_span_y) ||
                      (rsp_data.status      !== want.status);
               if (bad) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t: mismatch exp en=%0b l=%0d b=%0d w=%0d h=%0d st=%0d",
                              $realtime, want.clip_enable, want.clip_left,
                              want.clip_bottom, want.clip_span_x, want.clip_span_y,
                              want.status,
                              " got en=%0b l=%0d b=%0d w=%0d h=%0d st=%0d",
                              rsp_data.clip_enable, rsp_data.clip_left,
                              rsp_data.clip_bottom, rsp_data.clip_span_x,
                              rsp_data.clip_span_y, rsp_data.status);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            moved = 1'b1;
            want  = clip_after(req_data);
            if (req_data.opcode == crs_pkg::OP_PUSH) n_push++;
            else n_pop++;
            if (want.status == crs_pkg::ST_PUSH_FULL) n_push_full++;
            if (want.status == crs_pkg::ST_POP_EMPTY) n_pop_empty++;
            if (shadow_level > deepest) deepest = shadow_level;
            // a typed row overrides the predictor, which has still tracked the stack
            pending_clips.push_back(item_typed ? item_want : want);
         end
         if (moved) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
            $display("tb_clip_rect_stack NOT OK");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      crs_pkg::req_type  rq;
      crs_pkg::rsp_type  want;
      crs_pkg::rect_type top;
      int                push_pct;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, with the sender idling now and then
      foreach (dir_table[r]) begin
         rq.opcode        = dir_table[r].op;
         rq.left          = 16'(dir_table[r].left);
         rq.bottom        = 16'(dir_table[r].bottom);
         rq.span_x        = 15'(dir_table[r].span_x);
         rq.span_y        = 15'(dir_table[r].span_y);
         want.clip_enable = dir_table[r].w_en;
         want.clip_left   = 16'(dir_table[r].w_left);
         want.clip_bottom = 16'(dir_table[r].w_bottom);
         want.clip_span_x = 15'(dir_table[r].w_span_x);
         want.clip_span_y = 15'(dir_table[r].w_span_y);
         want.status      = dir_table[r].w_status;
         send_item(rq, dir_table[r].typed, want);
      end

      // random part: bias flips between filling, churning and draining the stack
      push_pct = 50;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3)
            send_idle_pct = 50;
         else if (i == 2 * RANDOM_ITEMS / 3)
            send_idle_pct = 0;
         if (i % 25 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 85;
               1: push_pct = 50;
               default: push_pct = 15;
            endcase
         end
         // pops carry random geometry that must be ignored
         rq.opcode = ($urandom_range(0, 99) < push_pct) ? crs_pkg::OP_PUSH : crs_pkg::OP_POP;
         rq.left   = 16'($urandom);
         rq.bottom = 16'($urandom);
         rq.span_x = 15'($urandom);
         rq.span_y = 15'($urandom);
         if (rq.opcode == crs_pkg::OP_PUSH) begin
            if (shadow_level > 0 && $urandom_range(0, 99) < 65) begin
               top       = shadow_rects[shadow_level - 1];
               rq.left   = 16'(jitter_coord(int'($signed(top.left))));
               rq.bottom = 16'(jitter_coord(int'($signed(top.bottom))));
               rq.span_x = 15'(jitter_span(int'(top.span_x)));
               rq.span_y = 15'(jitter_span(int'(top.span_y)));
            end else if ($urandom_range(0, 1) == 0) begin
               rq.left   = 16'(pick_coord());
               rq.bottom = 16'(pick_coord());
               rq.span_x = 15'(pick_span());
               rq.span_y = 15'(pick_span());
            end
         end
         send_item(rq, 1'b0, '0);
      end

      @(negedge clock);
      start <= 1'b0;

      // drain: the watchdog catches a response that never comes
      while (pending_clips.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (pending_clips.size() != 0)
         errors++;

      $display("covered %0d pushes (%0d on a full stack) and %0d pops (%0d on an empty one)",
               n_push, n_push_full, n_pop, n_pop_empty);
      $display("%0d responses checked, deepest stack level %0d, %0d errors",
               n_rsp, deepest, errors);
      if (errors == 0) begin
         $display("tb_clip_rect_stack OK");
      end else begin
         $display("tb_clip_rect_stack NOT OK");
      end
      $finish;
   end

endmodule
